/* design/sip_pkg.sv */
// ============================================================================
// sip_pkg: shared definitions for the slab intensity projection core
// Field widths, register indexes, projection modes and the records that
// travel between the classifier, the request queue and the update engine.
// ============================================================================
`default_nettype none

package sip_pkg;

  localparam int SLICE_W   = 10;
  localparam int PIX_W     = 16;
  localparam int VAL_W     = 8;
  localparam int ACC_W     = 18;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 10;

  localparam int MAX_PIXELS = 65536;
  localparam int MAX_SLICES = 1024;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);

  // Slice count of the slab, up to 1024 inclusive.
  localparam int CNT_W      = SLICE_W + 1;
  localparam int DIV_STAGES = VAL_W;
  localparam int DIV_W      = CNT_W + VAL_W;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [VAL_W-1:0]   VAL_MAX    = '1;
  localparam logic [SLICE_W-1:0] LAST_RESET = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_MAX  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MIN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MEAN = 2'd2;

  typedef struct packed {
    logic             is_first;
    logic             is_last;
    logic [PIX_W-1:0] pix;
    logic [VAL_W-1:0] val;
  } sip_entry_t;

  typedef struct packed {
    logic [SLICE_W-1:0] first;
    logic [SLICE_W-1:0] last;
  } sip_slab_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  count;
  } sip_proj_cfg_t;

  typedef struct packed {
    logic             mean;
    logic [PIX_W-1:0] pix;
    logic [VAL_W-1:0] direct;
  } sip_side_t;

endpackage

`default_nettype wire

/* design/slab_intensity_projection_core.sv */
// ============================================================================
// slab_intensity_projection_core: slab maximum, minimum or mean projection
// Keeps one accumulator per pixel over the configured slab of slices and
// emits each pixel's projection when its last slab slice arrives.
// ============================================================================
//
//   Channel  Direction  Handshake              Payload
//   in_      request    in_valid / in_ready    slice_index, pixel_index, pixel_value
//   out_     result     out_valid / out_ready  out_pixel_index, out_projected_value
//   cfg_     write      cfg_we                 cfg_index, cfg_wdata
//
// One sample is accepted per cycle while the request queue has room. A projection
// passes through the classifier, queue, accumulator read-modify-write, eight
// divider stages and the output register. The accumulator memory has no
// reset and needs no clearing pass. An output stall stops the update engine
// only; the classifier keeps accepting until the request queue fills.
`default_nettype none

module slab_intensity_projection_core
  import sip_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [SLICE_W-1:0]   in_slice_index,
  input  wire logic [PIX_W-1:0]     in_pixel_index,
  input  wire logic [VAL_W-1:0]     in_pixel_value,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PIX_W-1:0]          out_pixel_index,
  output logic [VAL_W-1:0]          out_projected_value,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic [MODE_W-1:0]  mode_r;
  logic [SLICE_W-1:0] first_r;
  logic [SLICE_W-1:0] last_r;
  sip_slab_t          slab;
  sip_proj_cfg_t      proj_cfg;
  logic               q_push;
  sip_entry_t         q_wr_entry;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  sip_entry_t         q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_MAX;
      first_r <= '0;
      last_r  <= LAST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE: begin
          mode_r <= cfg_wdata[MODE_W-1:0];
        end
        CFG_FIRST: begin
          first_r <= cfg_wdata[SLICE_W-1:0];
        end
        CFG_LAST: begin
          last_r <= cfg_wdata[SLICE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    slab.first     = first_r;
    slab.last      = last_r;
    proj_cfg.mode  = mode_r;
    proj_cfg.count = CNT_W'(last_r) - CNT_W'(first_r) + CNT_W'(1);
  end

  sip_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .slab    (slab),
    .s_valid (in_valid),
    .s_ready (in_ready),
    .s_slice (in_slice_index),
    .s_pix   (in_pixel_index),
    .s_val   (in_pixel_value),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_wr_entry)
  );

  sip_fifo #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .wr_entry   (q_wr_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  sip_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (proj_cfg),
    .q_valid (q_valid),
    .q_entry (q_head),
    .q_pop   (q_pop),
    .r_valid (out_valid),
    .r_ready (out_ready),
    .r_pix   (out_pixel_index),
    .r_val   (out_projected_value)
  );

endmodule

`default_nettype wire

/* design/sip_ram.sv */
// ============================================================================
// sip_ram: generic single-write, single-read memory
// One write port and one read port with a registered read data output.
// ============================================================================
`default_nettype none

module sip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* design/sip_fifo.sv */
// ============================================================================
// sip_fifo: request queue between classifier and update engine
// A short register queue that lets the two sides stall independently.
// ============================================================================
`default_nettype none

module sip_fifo
  import sip_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire sip_entry_t wr_entry,
  output logic            full,
  input  wire logic       pop,
  output logic            head_valid,
  output sip_entry_t      head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QCNT_W = $clog2(DEPTH + 1);

  sip_entry_t          mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [PTR_W-1:0]    wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_nxt;
  logic                do_push;
  logic                do_pop;

  assign full       = (count_r == QCNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(DEPTH))
    else $error("request queue holds more entries than its depth");

  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + QCNT_W'(1)))
    else $error("request queue count did not grow on a lone push");

endmodule

`default_nettype wire

/* design/sip_front.sv */
// ============================================================================
// sip_front: sample classifier
// Accepts samples, drops those outside the slab, marks first and last slab
// slices and hands the rest to the request queue.
// ============================================================================
`default_nettype none

module sip_front
  import sip_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sip_slab_t          slab,
  input  wire logic               s_valid,
  output logic                    s_ready,
  input  wire logic [SLICE_W-1:0] s_slice,
  input  wire logic [PIX_W-1:0]   s_pix,
  input  wire logic [VAL_W-1:0]   s_val,
  input  wire logic               q_full,
  output logic                    q_push,
  output sip_entry_t              q_entry
);

  logic       fr_valid_r;
  logic       fr_keep_r;
  sip_entry_t fr_entry_r;
  logic       keep_nxt;
  logic       accept;

  always_comb begin
    keep_nxt = (slab.first <= slab.last) && (32'(s_slice) < MAX_SLICES) &&
               (s_slice >= slab.first) && (s_slice <= slab.last);
  end

  assign q_push  = fr_valid_r && fr_keep_r && !q_full;
  assign s_ready = !fr_valid_r || !fr_keep_r || !q_full;
  assign accept  = s_valid && s_ready;
  assign q_entry = fr_entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (s_ready) begin
      fr_valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_keep_r           <= keep_nxt;
      fr_entry_r.is_first <= (s_slice == slab.first);
      fr_entry_r.is_last  <= (s_slice == slab.last);
      fr_entry_r.pix      <= s_pix;
      fr_entry_r.val      <= s_val;
    end
  end

endmodule

`default_nettype wire

/* design/sip_div.sv */
// ============================================================================
// sip_div: pipelined mean divider
// Restoring division of the accumulated sum by the slab slice count, one
// quotient bit per stage, with a saturation flag for quotients above 255.
// ============================================================================
`default_nettype none

module sip_div
  import sip_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic             d_valid,
  input  wire sip_side_t        d_side,
  input  wire logic [ACC_W-1:0] d_sum,
  output logic                  r_valid,
  output sip_side_t             r_side,
  output logic [VAL_W-1:0]      r_quot,
  output logic                  r_sat
);

  logic             vld_r  [DIV_STAGES];
  sip_side_t        side_r [DIV_STAGES];
  logic [ACC_W-1:0] rem_r  [DIV_STAGES];
  logic [VAL_W-1:0] quot_r [DIV_STAGES];
  logic             sat_r  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic             vld_in;
    sip_side_t        side_in;
    logic [ACC_W-1:0] rem_in;
    logic [VAL_W-1:0] quot_in;
    logic             sat_in;
    logic [DIV_W-1:0] dsh;
    logic [DIV_W-1:0] diff;
    logic             take;
    logic [ACC_W-1:0] rem_nxt;
    logic [VAL_W-1:0] quot_nxt;

    if (s == 0) begin : g_head
      assign vld_in  = d_valid;
      assign side_in = d_side;
      assign rem_in  = d_sum;
      assign quot_in = '0;
      assign sat_in  = (DIV_W'(d_sum) >= (DIV_W'(count) << VAL_W));
    end else begin : g_body
      assign vld_in  = vld_r[s-1];
      assign side_in = side_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign quot_in = quot_r[s-1];
      assign sat_in  = sat_r[s-1];
    end

    assign dsh  = DIV_W'(count) << (VAL_W - 1 - s);
    assign take = (DIV_W'(rem_in) >= dsh);
    assign diff = DIV_W'(rem_in) - dsh;

    always_comb begin
      rem_nxt  = take ? diff[ACC_W-1:0] : rem_in;
      quot_nxt = quot_in;
      quot_nxt[VAL_W-1-s] = take;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s] <= side_in;
        rem_r[s]  <= rem_nxt;
        quot_r[s] <= quot_nxt;
        sat_r[s]  <= sat_in;
      end
    end
  end

  assign r_valid = vld_r[DIV_STAGES-1];
  assign r_side  = side_r[DIV_STAGES-1];
  assign r_quot  = quot_r[DIV_STAGES-1];
  assign r_sat   = sat_r[DIV_STAGES-1];

endmodule

`default_nettype wire

/* design/sip_back.sv */
// ============================================================================
// sip_back: accumulator update engine
// Pops requests, updates the per-pixel accumulator memory with forwarding
// for back-to-back hits, and produces the projection through the divider.
// ============================================================================
`default_nettype none

module sip_back
  import sip_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sip_proj_cfg_t cfg,
  input  wire logic          q_valid,
  input  wire sip_entry_t    q_entry,
  output logic               q_pop,
  output logic               r_valid,
  input  wire logic          r_ready,
  output logic [PIX_W-1:0]   r_pix,
  output logic [VAL_W-1:0]   r_val
);

  logic              adv;
  logic              b1_valid_r;
  sip_entry_t        b1_entry_r;
  logic              fwd_valid_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  logic [ACC_W-1:0]  fwd_data_r;
  logic [ADDR_W-1:0] b1_addr;
  logic              fwd_hit;
  logic [ACC_W-1:0]  ram_rdata;
  logic [ACC_W-1:0]  acc_old;
  logic [ACC_W-1:0]  val_ext;
  logic [ACC_W-1:0]  acc_max;
  logic [ACC_W-1:0]  acc_new;
  logic [VAL_W-1:0]  direct;
  sip_side_t         b1_side;
  logic              div_valid;
  sip_side_t         div_side;
  logic [VAL_W-1:0]  div_quot;
  logic              div_sat;
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic [VAL_W-1:0]  out_val_r;

  assign adv   = !out_valid_r || r_ready;
  assign q_pop = adv && q_valid;

  sip_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_PIXELS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (adv && b1_valid_r),
    .waddr (b1_addr),
    .wdata (acc_new),
    .re    (q_pop),
    .raddr (q_entry.pix[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    b1_addr = b1_entry_r.pix[ADDR_W-1:0];
    fwd_hit = fwd_valid_r && (fwd_addr_r == b1_addr);
    acc_old = fwd_hit ? fwd_data_r : ram_rdata;
    val_ext = ACC_W'(b1_entry_r.val);
    acc_max = (val_ext > acc_old) ? val_ext : acc_old;
    if (b1_entry_r.is_first) begin
      acc_new = val_ext;
    end else begin
      case (cfg.mode)
        MODE_MAX: begin
          acc_new = acc_max;
        end
        MODE_MIN: begin
          acc_new = (val_ext < acc_old) ? val_ext : acc_old;
        end
        MODE_MEAN: begin
          acc_new = acc_old + val_ext;
        end
        default: begin
          acc_new = acc_max;
        end
      endcase
    end
    direct = (acc_new > ACC_W'(VAL_MAX)) ? VAL_MAX : acc_new[VAL_W-1:0];
    b1_side.mean   = (cfg.mode == MODE_MEAN);
    b1_side.pix    = b1_entry_r.pix;
    b1_side.direct = direct;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else if (adv) begin
      b1_valid_r  <= q_valid;
      fwd_valid_r <= b1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_entry_r <= q_entry;
      fwd_addr_r <= b1_addr;
      fwd_data_r <= acc_new;
    end
  end

  sip_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .count   (cfg.count),
    .d_valid (b1_valid_r && b1_entry_r.is_last),
    .d_side  (b1_side),
    .d_sum   (acc_new),
    .r_valid (div_valid),
    .r_side  (div_side),
    .r_quot  (div_quot),
    .r_sat   (div_sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix_r <= div_side.pix;
      if (div_side.mean) begin
        out_val_r <= div_sat ? VAL_MAX : div_quot;
      end else begin
        out_val_r <= div_side.direct;
      end
    end
  end

  assign r_valid = out_valid_r;
  assign r_pix   = out_pix_r;
  assign r_val   = out_val_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(b1_valid_r) && $stable(fwd_valid_r)))
    else $error("update stage moved while the engine was stalled");

  a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && b1_valid_r) |=> (fwd_valid_r && (fwd_addr_r == $past(b1_addr))))
    else $error("forwarding register missed the last accumulator write");

endmodule

`default_nettype wire

/* sim/slab_intensity_projection_core_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// slab_intensity_projection_core_tb: self-checking bench for the projection core
// Streams volume samples over valid/ready with random gaps and output stalls.
// A local model of the per-pixel accumulators predicts each maximum, minimum
// or mean projection. Every result is compared in order against that model.
// Directed requests cover the reset slab, empty and single-slice slabs, the
// spare mode, irregular slice order, mean saturation and a mode change inside
// a slab. A long output stall fills the core, and one pixel's sum wraps.
// Random phases then run well-formed slab sequences with noise mixed in.
// ============================================================================

module slab_intensity_projection_core_tb;
  import sip_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int SETTLE_CYCLES  = 40;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_SAMPLES = 200;
  localparam int REPORT_MAX     = 10;
  localparam int TIMEOUT_NS     = 10_000_000;

  typedef struct packed {
    logic [SLICE_W-1:0] slice;
    logic [PIX_W-1:0]   pix;
    logic [VAL_W-1:0]   val;
  } sample_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [VAL_W-1:0] value;
  } projection_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [SLICE_W-1:0] in_slice_index = '0;
  logic [PIX_W-1:0]   in_pixel_index = '0;
  logic [VAL_W-1:0]   in_pixel_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PIX_W-1:0]   out_pixel_index;
  logic [VAL_W-1:0]   out_projected_value;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MODE;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  logic [MODE_W-1:0]  cfg_mode = MODE_MAX;
  logic [SLICE_W-1:0] cfg_first = '0;
  logic [SLICE_W-1:0] cfg_last = LAST_RESET;

  logic [ACC_W-1:0] pixel_acc [MAX_PIXELS];
  bit               pix_loaded [MAX_PIXELS];
  sample_t          samples_to_send [$];
  projection_t      projections_due [$];
  logic [MODE_W-1:0] mode_choices [4] = '{MODE_MAX, MODE_MIN, MODE_MEAN, MODE_SPARE};

  int n_queued = 0;
  int n_accepted = 0;
  int n_errors = 0;
  int slab_samples = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit in_taken = 1'b0;
  bit out_hold = 1'b0;
  bit hold_go = 1'b0;
  sample_t     drv_sample;
  projection_t seen_due;

  slab_intensity_projection_core u_top (.*);

  always #5 clk = ~clk;

  function automatic int idle_len(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return MAX_PIXELS - 1;
    return $urandom_range(0, MAX_PIXELS - 1);
  endfunction

  function automatic int pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return int'(VAL_MAX);
    return $urandom_range(0, int'(VAL_MAX));
  endfunction

  task automatic note_error(input string msg);
    if (n_errors < REPORT_MAX) $display("%s", msg);
    n_errors++;
  endtask

  task automatic project_sample(input sample_t s);
    logic [ACC_W-1:0] acc;
    int quotient;
    if (cfg_first > cfg_last || s.slice < cfg_first || s.slice > cfg_last) return;
    if (s.slice == cfg_first) begin
      acc = ACC_W'(s.val);
    end else begin
      acc = pixel_acc[s.pix];
      case (cfg_mode)
        MODE_MIN: begin
          if (s.val < acc) acc = ACC_W'(s.val);
        end
        MODE_MEAN: begin
          acc = acc + ACC_W'(s.val);
        end
        default: begin
          if (s.val > acc) acc = ACC_W'(s.val);
        end
      endcase
    end
    pixel_acc[s.pix] = acc;
    if (s.slice != cfg_last) return;
    if (cfg_mode == MODE_MEAN) begin
      quotient = int'(acc) / (int'(cfg_last) - int'(cfg_first) + 1);
    end else begin
      quotient = int'(acc);
    end
    projections_due.push_back(projection_t'{pix: s.pix,
      value: (quotient > int'(VAL_MAX)) ? VAL_MAX : VAL_W'(quotient)});
  endtask

  // An update of a pixel that was never loaded is turned into a load.
  task automatic add_sample(input int slice, input int pix, input int val);
    sample_t s;
    bit in_slab;
    in_slab = cfg_first <= cfg_last && slice >= cfg_first && slice <= cfg_last;
    if (in_slab && slice != cfg_first && !pix_loaded[pix]) slice = int'(cfg_first);
    if (in_slab && slice == cfg_first) pix_loaded[pix] = 1'b1;
    if (in_slab) slab_samples++;
    s.slice = SLICE_W'(slice);
    s.pix = PIX_W'(pix);
    s.val = VAL_W'(val);
    samples_to_send.push_back(s);
    n_queued++;
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  task automatic configure(input logic [MODE_W-1:0] m, input int first, input int last);
    logic [CFG_W-1:0] mode_word;
    mode_word = CFG_W'($urandom);
    mode_word[MODE_W-1:0] = m;
    cfg_put(CFG_MODE, mode_word);
    cfg_put(CFG_FIRST, CFG_W'(first));
    cfg_put(CFG_LAST, CFG_W'(last));
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_mode = m;
    cfg_first = SLICE_W'(first);
    cfg_last = SLICE_W'(last);
  endtask

  task automatic drain();
    int waited;
    wait (n_accepted == n_queued);
    waited = 0;
    while (projections_due.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (projections_due.size() > 0) begin
      note_error($sformatf("%0d projections never arrived", projections_due.size()));
      projections_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_noise(input int p);
    int r;
    r = $urandom_range(0, 2);
    if (r == 0) begin
      add_sample($urandom_range(int'(cfg_first), int'(cfg_last)), p, pick_value());
    end else if (r == 1 && cfg_first > 0) begin
      add_sample($urandom_range(0, int'(cfg_first) - 1), pick_pixel(), pick_value());
    end else if (cfg_last < LAST_RESET) begin
      add_sample($urandom_range(int'(cfg_last) + 1, MAX_SLICES - 1), p, pick_value());
    end else begin
      add_sample($urandom_range(0, MAX_SLICES - 1), pick_pixel(), pick_value());
    end
  endtask

  // A group of pixels walks the slab slice by slice; a few groups stop early.
  task automatic slab_group(input int npix, input int noise_pct);
    int pix [8];
    int stop, rot, k, p, s;
    for (k = 0; k < npix; k++) pix[k] = pick_pixel();
    stop = int'(cfg_last);
    if ($urandom_range(0, 9) == 0) stop = $urandom_range(int'(cfg_first), int'(cfg_last));
    for (s = int'(cfg_first); s <= stop; s++) begin
      rot = $urandom_range(0, npix - 1);
      for (k = 0; k < npix; k++) begin
        p = pix[(k + rot) % npix];
        add_sample(s, p, pick_value());
        if ($urandom_range(0, 99) < noise_pct) add_noise(p);
      end
    end
  endtask

  task automatic random_setup();
    int r, first, last, len;
    r = $urandom_range(0, 19);
    first = $urandom_range(0, MAX_SLICES - 1);
    len = $urandom_range(2, 8);
    case (r)
      0: begin
        first = $urandom_range(1, MAX_SLICES - 1);
        last = $urandom_range(0, first - 1);
      end
      1: last = first;
      2: begin
        first = 0;
        last = len - 1;
      end
      3: begin
        last = MAX_SLICES - 1;
        first = last - len + 1;
      end
      default: last = (first + len - 1 > MAX_SLICES - 1) ? MAX_SLICES - 1 : first + len - 1;
    endcase
    configure(mode_choices[$urandom_range(0, 3)], first, last);
    in_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
    out_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
  endtask

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      project_sample(sample_t'{slice: in_slice_index, pix: in_pixel_index,
                               val: in_pixel_value});
      n_accepted++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (samples_to_send.size() > 0) begin
        drv_sample = samples_to_send.pop_front();
        in_valid <= 1'b1;
        in_slice_index <= drv_sample.slice;
        in_pixel_index <= drv_sample.pix;
        in_pixel_value <= drv_sample.val;
        in_gap = idle_len(in_idle_pct);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || out_hold) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap = out_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_gap = idle_len(out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (projections_due.size() == 0) begin
        note_error($sformatf("unexpected projection: pixel %0d value %0d",
                             out_pixel_index, out_projected_value));
      end else begin
        seen_due = projections_due.pop_front();
        if (out_pixel_index !== seen_due.pix || out_projected_value !== seen_due.value) begin
          note_error($sformatf("projection mismatch: expected pixel %0d value %0d, got %0d %0d",
                               seen_due.pix, seen_due.value,
                               out_pixel_index, out_projected_value));
        end
      end
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    out_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold = 1'b0;
  end

  initial begin
    #TIMEOUT_NS;
    $display("slab_intensity_projection_core_tb: done, errors");
    $finish;
  end

  initial begin
    int wrap_pix, target, one_slice;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_sample(0, 0, 255);
    add_sample(512, 0, 17);
    add_sample(1023, 0, 0);
    drain();
    configure(MODE_MIN, 0, 2);
    add_sample(0, 65535, 200);
    add_sample(1, 65535, 0);
    add_sample(2, 65535, 255);
    drain();
    configure(MODE_MEAN, 1023, 1023);
    add_sample(1023, 65535, 255);
    add_sample(1023, 16'h5A5A, 0);
    add_sample(1022, 7, 9);
    drain();
    configure(MODE_MAX, 1023, 0);
    add_sample(0, 1, 1);
    add_sample(1023, 2, 2);
    add_sample(500, 3, 3);
    drain();
    configure(MODE_SPARE, 0, 1);
    add_sample(0, 16'h1234, 100);
    add_sample(1, 16'h1234, 200);
    add_sample(1, 16'h1234, 50);
    drain();
    configure(MODE_MEAN, 0, 1);
    add_sample(0, 16'h00FF, 255);
    add_sample(1, 16'h00FF, 255);
    add_sample(1, 16'h00FF, 255);
    drain();
    configure(MODE_MAX, 0, 1);
    add_sample(1, 16'h00FF, 3);
    drain();

    // Enough repeated slices to carry one pixel's sum past 18 bits.
    configure(MODE_MEAN, 0, 2);
    in_idle_pct = 20;
    out_idle_pct = 20;
    wrap_pix = pick_pixel();
    add_sample(0, wrap_pix, 255);
    repeat (1028) add_sample(1, wrap_pix, 255);
    add_sample(2, wrap_pix, 255);
    drain();

    one_slice = $urandom_range(0, MAX_SLICES - 1);
    configure(mode_choices[$urandom_range(0, 3)], one_slice, one_slice);
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_go = 1'b1;
    repeat (150) add_sample(one_slice, pick_pixel(), pick_value());
    drain();

    target = slab_samples + RANDOM_SAMPLES;
    while (slab_samples < target) begin
      random_setup();
      if (cfg_first > cfg_last) begin
        repeat (12) add_sample($urandom_range(0, MAX_SLICES - 1), pick_pixel(), pick_value());
      end else begin
        repeat ($urandom_range(1, 4)) slab_group($urandom_range(1, 6), 8);
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("slab_intensity_projection_core_tb: done, clean");
    end else begin
      $display("slab_intensity_projection_core_tb: done, errors");
    end
    $finish;
  end

endmodule
